@@ rtl/core/psh_pkg.sv @@
package psh_pkg;

    localparam int BIN_COUNT = 4096;
    localparam int BIN_W     = $clog2(BIN_COUNT);
    localparam int EFF_W     = BIN_W + 2;

    localparam int PC_W    = 32;
    localparam int TICK_W  = 16;
    localparam int RBIN_W  = 12;
    localparam int SCALE_W = 17;
    localparam int BUF_W   = 14;
    localparam int DATA_W  = 16;
    localparam int FRAC_W  = 16;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1 << FRAC_W);

    localparam logic [1:0] REG_PC_OFFSET = 2'd0;
    localparam logic [1:0] REG_SCALE     = 2'd1;
    localparam logic [1:0] REG_BUFFER    = 2'd2;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    typedef struct packed {
        logic [PC_W-1:0]    pc_offset;
        logic [SCALE_W-1:0] scale;
        logic [EFF_W-1:0]   eff_bytes;
    } cfg_t;

    typedef struct packed {
        logic               req;
        logic               hit;
        logic [BIN_W-1:0]   bin;
        logic [RBIN_W-1:0]  bin_number;
        logic [TICK_W-1:0]  ticks;
    } bin_item_t;

endpackage

@@ rtl/core/psh_ram.sv @@
module psh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/psh_regs.sv @@
module psh_regs
    import psh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    localparam int CAP_BYTES = 2 * BIN_COUNT;

    logic [PC_W-1:0]    pc_offset_reg, pc_offset_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic [BUF_W-1:0]   buffer_reg, buffer_next;
    logic [1:0]         idx;
    logic               wr;

    assign idx = paddr[3:2];
    assign wr  = psel && penable && pwrite;

    always_comb begin
        pc_offset_next = pc_offset_reg;
        scale_next     = scale_reg;
        buffer_next    = buffer_reg;
        if (wr) begin
            unique case (idx)
                REG_PC_OFFSET: pc_offset_next = pwdata[PC_W-1:0];
                REG_SCALE:     scale_next     = pwdata[SCALE_W-1:0];
                REG_BUFFER:    buffer_next    = pwdata[BUF_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_offset_reg <= '0;
            scale_reg     <= '0;
            buffer_reg    <= '0;
        end else begin
            pc_offset_reg <= pc_offset_next;
            scale_reg     <= scale_next;
            buffer_reg    <= buffer_next;
        end
    end

    always_comb begin
        unique case (idx)
            REG_PC_OFFSET: prdata = APB_DW'(pc_offset_reg);
            REG_SCALE:     prdata = APB_DW'(scale_reg);
            REG_BUFFER:    prdata = APB_DW'(buffer_reg);
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // scale above 1.0 saturates, size saturates at the store
    assign cfg.pc_offset = pc_offset_reg;
    assign cfg.scale     = (scale_reg > SCALE_ONE) ? SCALE_ONE : scale_reg;
    assign cfg.eff_bytes = (32'(buffer_reg) < 32'(CAP_BYTES)) ? EFF_W'(buffer_reg)
                                                              : EFF_W'(CAP_BYTES);

endmodule

@@ rtl/core/psh_front.sv @@
module psh_front
    import psh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              clr_busy,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_req_type,
    input  logic [PC_W-1:0]   s_pc,
    input  logic [TICK_W-1:0] s_ticks,
    input  logic [RBIN_W-1:0] s_read_bin,
    output logic              item_valid,
    output bin_item_t         item,
    input  logic              item_ready
);

    // stage 1: offset subtract
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_req_reg, s1_req_next;
    logic              s1_skip_reg, s1_skip_next;
    logic [PC_W-1:0]   s1_diff_reg, s1_diff_next;
    logic [TICK_W-1:0] s1_ticks_reg;
    logic [RBIN_W-1:0] s1_rbin_reg;
    // stage 2: scale multiply
    logic              s2_valid_reg, s2_valid_next;
    logic              s2_req_reg, s2_skip_reg;
    logic [PC_W-1:0]   s2_off_reg, s2_off_next;
    logic [TICK_W-1:0] s2_ticks_reg;
    logic [RBIN_W-1:0] s2_rbin_reg;
    // stage 3: bin check
    logic              s3_valid_reg, s3_valid_next;
    bin_item_t         s3_item_reg, s3_item_next;

    logic                      en1, en2, en3, acc;
    logic [PC_W:0]             diff_w;
    logic [PC_W+SCALE_W-1:0]   prod;
    logic [PC_W-1:0]           byte_off;
    logic                      in_range, fits, ok;

    assign en3     = !s3_valid_reg || item_ready;
    assign en2     = !s2_valid_reg || en3;
    assign en1     = !s1_valid_reg || en2;
    assign s_ready = en1 && !clr_busy;
    assign acc     = s_valid && s_ready;

    always_comb begin
        diff_w        = {1'b0, s_pc} - {1'b0, cfg.pc_offset};
        s1_diff_next  = diff_w[PC_W-1:0];
        s1_req_next   = s_req_type;
        s1_skip_next  = (s_req_type == REQ_SAMPLE) &&
                        ((cfg.scale == '0) || (s_ticks == '0) || diff_w[PC_W]);
        s1_valid_next = acc ? 1'b1 : (en2 ? 1'b0 : s1_valid_reg);
    end

    always_comb begin
        prod          = s1_diff_reg * cfg.scale;
        s2_off_next   = prod[PC_W+FRAC_W-1:FRAC_W];
        s2_valid_next = (en2 && s1_valid_reg) ? 1'b1 : (en3 ? 1'b0 : s2_valid_reg);
    end

    always_comb begin
        if (s2_req_reg == REQ_READ) begin
            byte_off = PC_W'({s2_rbin_reg, 1'b0});
        end else begin
            byte_off = {s2_off_reg[PC_W-1:1], 1'b0};
        end
        in_range = (byte_off >> (BIN_W + 1)) == '0;
        fits     = (EFF_W'(byte_off[BIN_W:0]) + EFF_W'(2)) <= cfg.eff_bytes;
        ok       = !s2_skip_reg && in_range && fits;

        s3_item_next.req   = s2_req_reg;
        s3_item_next.hit   = ok;
        s3_item_next.bin   = byte_off[BIN_W:1];
        s3_item_next.ticks = s2_ticks_reg;
        if (s2_req_reg == REQ_READ) begin
            s3_item_next.bin_number = s2_rbin_reg;
        end else if (ok) begin
            s3_item_next.bin_number = RBIN_W'(byte_off[BIN_W:1]);
        end else begin
            s3_item_next.bin_number = '0;
        end
        s3_valid_next = (en3 && s2_valid_reg) ? 1'b1 : (item_ready ? 1'b0 : s3_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_req_reg   <= s1_req_next;
            s1_skip_reg  <= s1_skip_next;
            s1_diff_reg  <= s1_diff_next;
            s1_ticks_reg <= s_ticks;
            s1_rbin_reg  <= s_read_bin;
        end
        if (en2) begin
            s2_req_reg   <= s1_req_reg;
            s2_skip_reg  <= s1_skip_reg;
            s2_off_reg   <= s2_off_next;
            s2_ticks_reg <= s1_ticks_reg;
            s2_rbin_reg  <= s1_rbin_reg;
        end
        if (en3) begin
            s3_item_reg <= s3_item_next;
        end
    end

    assign item_valid = s3_valid_reg;
    assign item       = s3_item_reg;

endmodule

@@ rtl/core/psh_bins.sv @@
module psh_bins
    import psh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    input  bin_item_t         item,
    output logic              item_ready,
    output logic              clr_busy,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_hit,
    output logic [RBIN_W-1:0] m_bin_number,
    output logic [DATA_W-1:0] m_count
);

    logic              clr_busy_reg, clr_busy_next;
    logic [BIN_W-1:0]  clr_idx_reg, clr_idx_next;

    logic              s4_valid_reg, s4_valid_next;
    bin_item_t         s4_item_reg;
    logic              fwd_reg, fwd_next;
    logic [DATA_W-1:0] fwd_data_reg;

    logic              m_valid_reg, m_valid_next;
    logic              m_hit_reg;
    logic [RBIN_W-1:0] m_bin_reg;
    logic [DATA_W-1:0] m_count_reg, m_count_next;

    logic              en_out, en4, wr_now;
    logic [DATA_W-1:0] rdata, base, new_count;
    logic              ram_we;
    logic [BIN_W-1:0]  ram_waddr;
    logic [DATA_W-1:0] ram_wdata;

    assign en_out     = !m_valid_reg || m_ready;
    assign en4        = !s4_valid_reg || en_out;
    assign item_ready = en4;
    assign clr_busy   = clr_busy_reg;

    // write of the item leaving s4 is not yet in the ram read data of the next one
    assign base      = fwd_reg ? fwd_data_reg : rdata;
    assign new_count = base + s4_item_reg.ticks;
    assign wr_now    = s4_valid_reg && en_out && s4_item_reg.hit &&
                       (s4_item_reg.req == REQ_SAMPLE);

    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_idx_next  = clr_idx_reg;
        if (clr_busy_reg) begin
            clr_idx_next  = clr_idx_reg + 1'b1;
            clr_busy_next = clr_idx_reg != BIN_W'(BIN_COUNT - 1);
        end
    end

    always_comb begin
        ram_we    = clr_busy_reg || wr_now;
        ram_waddr = clr_busy_reg ? clr_idx_reg : s4_item_reg.bin;
        ram_wdata = clr_busy_reg ? '0 : new_count;
    end

    always_comb begin
        s4_valid_next = en4 ? item_valid : s4_valid_reg;
        fwd_next      = wr_now && (s4_item_reg.bin == item.bin);
        m_valid_next  = en_out ? s4_valid_reg : m_valid_reg;
        if (!s4_item_reg.hit) begin
            m_count_next = '0;
        end else if (s4_item_reg.req == REQ_SAMPLE) begin
            m_count_next = new_count;
        end else begin
            m_count_next = base;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_idx_reg  <= clr_idx_next;
            s4_valid_reg <= s4_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            s4_item_reg  <= item;
            fwd_reg      <= fwd_next;
            fwd_data_reg <= new_count;
        end
        if (en_out) begin
            m_hit_reg   <= s4_item_reg.hit;
            m_bin_reg   <= s4_item_reg.bin_number;
            m_count_reg <= m_count_next;
        end
    end

    psh_ram #(
        .WIDTH (DATA_W),
        .DEPTH (BIN_COUNT)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (en4),
        .raddr (item.bin),
        .rdata (rdata)
    );

    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_bin_number = m_bin_reg;
    assign m_count      = m_count_reg;

endmodule

@@ rtl/core/pc_sample_histogram_core.sv @@
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  s_req_type, s_pc, s_ticks, s_read_bin
// m_        out        m_valid / m_ready  m_hit, m_bin_number, m_count
// apb       in         psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// one item per cycle unless m_ready is low or the clearing pass runs; each item goes through the stages below
// stages: offset subtract, scale multiply, bin check, ram read and add, output register
// the single-port-write bin ram sets the rate, back-to-back hits on one bin are forwarded
// after reset a clearing pass zeroes all 4096 ram entries with s_ready low
// m_ready low holds the output, the stages fill behind it before s_ready drops
module pc_sample_histogram_core
    import psh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_req_type,
    input  logic [PC_W-1:0]   s_pc,
    input  logic [TICK_W-1:0] s_ticks,
    input  logic [RBIN_W-1:0] s_read_bin,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_hit,
    output logic [RBIN_W-1:0] m_bin_number,
    output logic [DATA_W-1:0] m_count
);

    cfg_t      cfg;
    logic      clr_busy;
    logic      item_valid;
    logic      item_ready;
    bin_item_t item;

    psh_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    psh_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .clr_busy   (clr_busy),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_pc       (s_pc),
        .s_ticks    (s_ticks),
        .s_read_bin (s_read_bin),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready)
    );

    psh_bins u_bins (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (item_valid),
        .item         (item),
        .item_ready   (item_ready),
        .clr_busy     (clr_busy),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit),
        .m_bin_number (m_bin_number),
        .m_count      (m_count)
    );

endmodule

@@ rtl/core/psh_checker.sv @@
module psh_checker
    import psh_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_hit,
    input logic [RBIN_W-1:0] m_bin_number,
    input logic [DATA_W-1:0] m_count
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_bin_number)
                                && $stable(m_count))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_count == '0)
        else $error("count nonzero on a miss");

    a_clear_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !s_ready)
        else $error("item taken before the bin store is cleared");

    a_idle_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_valid)
        else $error("result present right after reset");

    a_no_result_early: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |=> !m_valid)
        else $error("result without an accepted item");

endmodule

bind pc_sample_histogram_core psh_checker u_psh_checker (.*);

@@ verif/tb_pc_sample_histogram_core.sv @@
`timescale 1ns / 100ps

module tb_pc_sample_histogram_core;
    import psh_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int SETTLE_CYCLES   = 8;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic              hit;
        logic [RBIN_W-1:0] bin_number;
        logic [DATA_W-1:0] count;
    } bin_result_t;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [1:0]        reg_idx;
        logic [31:0]       value;
        logic              req;
        logic [PC_W-1:0]   pc;
        logic [TICK_W-1:0] ticks;
        logic [RBIN_W-1:0] rbin;
        bit                typed;
        bin_result_t       want;
    } stim_row_t;

    logic              aclk       = 1'b0;
    logic              aresetn    = 1'b0;
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [APB_AW-1:0] paddr      = '0;
    logic [APB_DW-1:0] pwdata     = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_valid    = 1'b0;
    logic              s_ready;
    logic              s_req_type = 1'b0;
    logic [PC_W-1:0]   s_pc       = '0;
    logic [TICK_W-1:0] s_ticks    = '0;
    logic [RBIN_W-1:0] s_read_bin = '0;
    logic              m_valid;
    logic              m_ready    = 1'b0;
    logic              m_hit;
    logic [RBIN_W-1:0] m_bin_number;
    logic [DATA_W-1:0] m_count;

    // shadow of the block state
    logic [DATA_W-1:0]  bin_counts [BIN_COUNT];
    logic [PC_W-1:0]    cfg_pc_offset;
    logic [SCALE_W-1:0] cfg_scale;
    logic [BUF_W-1:0]   cfg_buf_bytes;

    bin_result_t expected_bins [$];
    stim_row_t   directed [$];
    int          n_fail      = 0;
    int          idle_cycles = 0;
    bit          src_steady  = 1'b0;
    bit          snk_steady  = 1'b0;

    pc_sample_histogram_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_pc         (s_pc),
        .s_ticks      (s_ticks),
        .s_read_bin   (s_read_bin),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit),
        .m_bin_number (m_bin_number),
        .m_count      (m_count)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic longint unsigned eff_bytes();
        return (cfg_buf_bytes > BUF_W'(2 * BIN_COUNT)) ? 64'(2 * BIN_COUNT)
                                                        : 64'(cfg_buf_bytes);
    endfunction

    function automatic bit bin_in_buffer(longint unsigned b);
        return b < BIN_COUNT && b * 2 + 2 <= eff_bytes();
    endfunction

    function automatic longint unsigned eff_scale();
        return (cfg_scale > SCALE_ONE) ? 64'(SCALE_ONE) : 64'(cfg_scale);
    endfunction

    function automatic bin_result_t profile_item(logic req, logic [PC_W-1:0] pc,
                                                 logic [TICK_W-1:0] ticks,
                                                 logic [RBIN_W-1:0] rbin);
        bin_result_t     r;
        longint unsigned sc;
        longint unsigned prod;
        longint unsigned bidx;
        r  = '0;
        sc = eff_scale();
        if (req == REQ_READ) begin
            r.bin_number = rbin;
            if (bin_in_buffer(rbin)) begin
                r.hit   = 1'b1;
                r.count = bin_counts[rbin];
            end
            return r;
        end
        if (sc == 0 || ticks == 0 || pc < cfg_pc_offset)
            return r;
        prod = (64'(pc - cfg_pc_offset) * sc) >> FRAC_W;
        bidx = (prod & ~64'd1) >> 1;
        if (!bin_in_buffer(bidx))
            return r;
        bin_counts[bidx] = bin_counts[bidx] + ticks;
        r.hit        = 1'b1;
        r.bin_number = bidx[RBIN_W-1:0];
        r.count      = bin_counts[bidx];
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic [1:0] idx, logic [31:0] val);
        stim_row_t r;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.value   = val;
        r.req     = REQ_SAMPLE;
        r.pc      = '0;
        r.ticks   = '0;
        r.rbin    = '0;
        r.typed   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    function automatic stim_row_t item_row(logic req, logic [PC_W-1:0] pc,
                                           logic [TICK_W-1:0] ticks,
                                           logic [RBIN_W-1:0] rbin);
        stim_row_t r;
        r       = cfg_row(REG_UNUSED, '0);
        r.kind  = ROW_ITEM;
        r.req   = req;
        r.pc    = pc;
        r.ticks = ticks;
        r.rbin  = rbin;
        return r;
    endfunction

    function automatic stim_row_t typed_row(logic req, logic [PC_W-1:0] pc,
                                            logic [TICK_W-1:0] ticks,
                                            logic [RBIN_W-1:0] rbin, logic hit,
                                            logic [RBIN_W-1:0] bnum,
                                            logic [DATA_W-1:0] cnt);
        stim_row_t r;
        r       = item_row(req, pc, ticks, rbin);
        r.typed = 1'b1;
        r.want  = '{hit: hit, bin_number: bnum, count: cnt};
        return r;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PC_OFFSET: cfg_pc_offset = val;
            REG_SCALE:     cfg_scale     = val[SCALE_W-1:0];
            REG_BUFFER:    cfg_buf_bytes = val[BUF_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_item(input logic req, input logic [PC_W-1:0] pc,
                             input logic [TICK_W-1:0] ticks,
                             input logic [RBIN_W-1:0] rbin,
                             input bit typed, input bin_result_t want);
        int          gap;
        bin_result_t pred;
        if ($urandom_range(63, 0) == 0)
            src_steady = !src_steady;
        gap = src_steady ? 0 : $urandom_range(15, 0);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_pc       <= pc;
        s_ticks    <= ticks;
        s_read_bin <= rbin;
        do @(posedge aclk); while (!s_ready);
        pred = profile_item(req, pc, ticks, rbin);
        expected_bins.push_back(typed ? want : pred);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_bins.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input int n_items);
        int                k;
        int                pick;
        logic              req;
        logic [PC_W-1:0]   pc;
        logic [PC_W-1:0]   last_pc;
        logic [TICK_W-1:0] ticks;
        logic [RBIN_W-1:0] rbin;
        longint unsigned   span;
        longint unsigned   rmax;
        // window of pcs that lands inside the buffer, plus a little past it
        span = (eff_scale() == 0) ? 64'hFFFF : ((eff_bytes() + 2) << FRAC_W) / eff_scale();
        if (span > 64'hFFFF_FFFF)
            span = 64'hFFFF_FFFF;
        rmax = eff_bytes() / 2 + 1;
        if (rmax > BIN_COUNT - 1)
            rmax = BIN_COUNT - 1;
        last_pc = cfg_pc_offset;
        for (k = 0; k < n_items; k++) begin
            pick  = $urandom_range(15, 0);
            req   = REQ_SAMPLE;
            pc    = cfg_pc_offset + $urandom_range(span[31:0], 0);
            ticks = TICK_W'($urandom_range(16'hFFFF, 1));
            rbin  = RBIN_W'($urandom());
            case (pick)
                9, 10: pc = last_pc;
                11, 12: begin
                    req  = REQ_READ;
                    rbin = RBIN_W'($urandom_range(rmax[31:0], 0));
                end
                13: begin
                    req   = 1'($urandom());
                    pc    = $urandom();
                    ticks = TICK_W'($urandom());
                end
                14: pc = cfg_pc_offset - 1 - $urandom_range(255, 0);
                15: ticks = $urandom_range(1, 0) ? '0 : '1;
                default: ;
            endcase
            if (req == REQ_SAMPLE)
                last_pc = pc;
            send_item(req, pc, ticks, rbin, 1'b0, '0);
        end
        drain();
    endtask

    initial begin
        int stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if ($urandom_range(63, 0) == 0)
                snk_steady = !snk_steady;
            stall = snk_steady ? 0 : $urandom_range(15, 0);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        bin_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bins.size() == 0) begin
                $error("unexpected item: m_hit %0d m_bin_number %0d m_count %0d",
                       m_hit, m_bin_number, m_count);
                n_fail++;
            end else begin
                want = expected_bins.pop_front();
                if (m_hit !== want.hit) begin
                    $error("m_hit mismatch: expected %0d, got %0d", want.hit, m_hit);
                    n_fail++;
                end
                if (m_bin_number !== want.bin_number) begin
                    $error("m_bin_number mismatch: expected %0d, got %0d",
                           want.bin_number, m_bin_number);
                    n_fail++;
                end
                if (m_count !== want.count) begin
                    $error("m_count mismatch: expected %0d, got %0d", want.count, m_count);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) ||
            (psel && penable && pwrite && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int          p;
        logic [31:0] off;
        logic [31:0] sc;
        logic [31:0] bb;
        foreach (bin_counts[i])
            bin_counts[i] = '0;
        cfg_pc_offset = '0;
        cfg_scale     = '0;
        cfg_buf_bytes = '0;

        directed = '{
            // registers at reset: nothing valid, profiling off
            typed_row(REQ_READ,   32'h0, 16'd0, 12'd0,   1'b0, 12'd0,   16'd0),
            typed_row(REQ_READ,   32'h0, 16'd0, 12'hFFF, 1'b0, 12'hFFF, 16'd0),
            typed_row(REQ_SAMPLE, 32'h0, 16'd1, 12'd0,   1'b0, 12'd0,   16'd0),
            cfg_row(REG_PC_OFFSET, 32'h0000_1000),
            cfg_row(REG_SCALE,     32'h0001_0000),
            cfg_row(REG_BUFFER,    32'd8192),
            cfg_row(REG_UNUSED,    32'hFFFF_FFFF),
            typed_row(REQ_READ,   32'h0,         16'd0,     12'd4095, 1'b1, 12'd4095, 16'd0),
            typed_row(REQ_SAMPLE, 32'h0000_0FFF, 16'd5,     12'd0,    1'b0, 12'd0,    16'd0),
            typed_row(REQ_SAMPLE, 32'h0000_1000, 16'd0,     12'd0,    1'b0, 12'd0,    16'd0),
            typed_row(REQ_SAMPLE, 32'h0000_1000, 16'hFFFF,  12'd0,    1'b1, 12'd0,    16'hFFFF),
            typed_row(REQ_SAMPLE, 32'h0000_1001, 16'd1,     12'd0,    1'b1, 12'd0,    16'd0),
            typed_row(REQ_SAMPLE, 32'h0000_2FFE, 16'd3,     12'd0,    1'b1, 12'd4095, 16'd3),
            typed_row(REQ_SAMPLE, 32'h0000_3000, 16'd1,     12'd0,    1'b0, 12'd0,    16'd0),
            typed_row(REQ_SAMPLE, 32'hFFFF_FFFF, 16'd1,     12'd0,    1'b0, 12'd0,    16'd0),
            typed_row(REQ_READ,   32'h0,         16'd0,     12'd4095, 1'b1, 12'd4095, 16'd3),
            // scale above one, odd buffer size
            cfg_row(REG_PC_OFFSET, 32'h0),
            cfg_row(REG_SCALE,     32'h0001_FFFF),
            cfg_row(REG_BUFFER,    32'd7),
            typed_row(REQ_SAMPLE, 32'd4, 16'd2, 12'd0, 1'b1, 12'd2, 16'd2),
            typed_row(REQ_SAMPLE, 32'd6, 16'd2, 12'd0, 1'b0, 12'd0, 16'd0),
            typed_row(REQ_READ,   32'd0, 16'd0, 12'd3, 1'b0, 12'd3, 16'd0),
            typed_row(REQ_READ,   32'd0, 16'd0, 12'd2, 1'b1, 12'd2, 16'd2),
            // smallest scale, oversized buffer, top offset
            cfg_row(REG_PC_OFFSET, 32'hFFFF_FFFF),
            cfg_row(REG_SCALE,     32'd1),
            cfg_row(REG_BUFFER,    32'd16383),
            typed_row(REQ_SAMPLE, 32'hFFFF_FFFF, 16'd7, 12'd0,    1'b1, 12'd0,    16'd7),
            typed_row(REQ_SAMPLE, 32'hFFFF_FFFE, 16'd1, 12'd0,    1'b0, 12'd0,    16'd0),
            typed_row(REQ_READ,   32'h0,         16'd0, 12'd4095, 1'b1, 12'd4095, 16'd3),
            // half scale, consecutive hits on one bin
            cfg_row(REG_PC_OFFSET, 32'h0),
            cfg_row(REG_SCALE,     32'h0000_8000),
            cfg_row(REG_BUFFER,    32'd8192),
            item_row(REQ_SAMPLE, 32'hFFFF_FFFF, 16'd1,     12'd0),
            item_row(REQ_SAMPLE, 32'd12,        16'h8000,  12'd0),
            item_row(REQ_SAMPLE, 32'd13,        16'h8000,  12'd0),
            item_row(REQ_READ,   32'hFFFF_FFFF, 16'hFFFF,  12'd3),
            item_row(REQ_SAMPLE, 32'd12,        16'd1,     12'hFFF)
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG) begin
                drain();
                write_reg(directed[i].reg_idx, directed[i].value);
            end else begin
                send_item(directed[i].req, directed[i].pc, directed[i].ticks,
                          directed[i].rbin, directed[i].typed, directed[i].want);
            end
        end
        drain();

        for (p = 0; p < N_PHASES; p++) begin
            off = $urandom();
            sc  = $urandom_range(32'h1_FFFF, 1);
            bb  = $urandom_range(16383, 0);
            case (p)
                0: begin
                    sc = 32'(SCALE_ONE);
                    bb = 8192;
                end
                1: begin
                    off = '0;
                    sc  = 1;
                    bb  = 16383;
                end
                2: begin
                    off = 32'hFFFF_F000;
                    sc  = 32'h1_FFFF;
                    bb  = 1;
                end
                3: sc = '0;
                4: begin
                    sc = 32'(SCALE_ONE);
                    bb = $urandom_range(64, 2);
                end
                default: ;
            endcase
            write_reg(REG_PC_OFFSET, off);
            write_reg(REG_SCALE, sc);
            write_reg(REG_BUFFER, bb);
            run_phase(ITEMS_PER_PHASE);
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_bins.size() != 0) begin
            $error("%0d expected items never arrived", expected_bins.size());
            n_fail++;
        end
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
